// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, held off during reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication check on the rising edge, held off during reset
`define ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/wbps_pkg.sv =====
// types and constants of the wildcard byte pattern search
// no dependencies
package wbps_pkg;

	localparam int MaxPattern  = 16;
	localparam int WindowDepth = 16;
	localparam int OffsetBits  = 32;
	localparam int LenBits     = 5;
	localparam int CfgIdxBits  = 2;
	localparam int CfgDataBits = 64;

	localparam logic [7:0] WildcardByte = 8'h3F;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} cfg_reg_t;

	typedef logic [WindowDepth-1:0][7:0] window_t;
	typedef logic [MaxPattern-1:0][7:0]  pattern_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_end;
	} wbps_in_t;

	typedef struct packed {
		logic                  match_found;
		logic [OffsetBits-1:0] match_offset;
	} wbps_out_t;

endpackage

// ===== hw/rtl/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search. One byte beat is taken every cycle while
// byte_ready is high; its result (match offset, or not-found at the region
// end) shows on the result channel from the cycle after the beat, later only
// while earlier results wait there. All pattern lengths are compared in
// parallel, combinationally, on the window register shifted by the new byte
// and on the next region count. A two-entry output buffer lets bytes keep
// flowing while a result waits; byte_ready drops only with both entries full.
// Depends on wbps_pkg, wbps_match and wbps_skid.
module wildcard_byte_pattern_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  wbps_pkg::wbps_in_t                  byte_item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output wbps_pkg::wbps_out_t                 result_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wbps_pkg::CfgIdxBits-1:0]     cfg_index,
	input  logic [wbps_pkg::CfgDataBits-1:0]    cfg_data
);

	logic [wbps_pkg::CfgDataBits-1:0] pat_low_q;
	logic [wbps_pkg::CfgDataBits-1:0] pat_high_q;
	logic [wbps_pkg::LenBits-1:0]     pat_len_q;

	wbps_pkg::window_t                window_q;
	logic [wbps_pkg::OffsetBits-1:0]  count_q;
	logic                             matched_q;

	wbps_pkg::window_t                window_next;
	wbps_pkg::pattern_t               pattern;
	logic [wbps_pkg::LenBits-1:0]     active_len;
	logic [wbps_pkg::OffsetBits-1:0]  count_next;
	logic [wbps_pkg::OffsetBits-1:0]  len_wide;
	logic                             hit;
	logic                             found;
	logic                             beat;
	logic                             push;
	logic                             space;
	wbps_pkg::wbps_out_t              push_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= wbps_pkg::LenBits'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				wbps_pkg::REG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				wbps_pkg::REG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				wbps_pkg::REG_PATTERN_LENGTH: pat_len_q  <= cfg_data[wbps_pkg::LenBits-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize clips to the pattern store
	always_comb begin
		if (pat_len_q == '0) begin
			active_len = wbps_pkg::LenBits'(1);
		end else if (pat_len_q > wbps_pkg::LenBits'(wbps_pkg::MaxPattern)) begin
			active_len = wbps_pkg::LenBits'(wbps_pkg::MaxPattern);
		end else begin
			active_len = pat_len_q;
		end
	end

	assign pattern     = {pat_high_q, pat_low_q};
	assign window_next = {window_q[wbps_pkg::WindowDepth-2:0], byte_item.data_byte};
	assign count_next  = (&count_q) ? count_q : count_q + 1'b1;
	assign len_wide    = wbps_pkg::OffsetBits'(active_len);

	wbps_match u_match (
		.window     (window_next),
		.pattern    (pattern),
		.active_len (active_len),
		.hit        (hit)
	);

	assign found      = hit && (count_next >= len_wide);
	assign byte_ready = space;
	assign beat       = byte_valid && byte_ready;
	assign push       = beat && !matched_q && (found || byte_item.region_end);

	assign push_data.match_found  = found;
	assign push_data.match_offset = found ? (count_next - len_wide) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			count_q   <= '0;
			matched_q <= 1'b0;
		end else if (beat) begin
			if (byte_item.region_end) begin
				window_q  <= '0;
				count_q   <= '0;
				matched_q <= 1'b0;
			end else if (!matched_q) begin
				window_q  <= window_next;
				count_q   <= count_next;
				matched_q <= found;
			end
		end
	end

	wbps_skid u_skid (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_data    (push_data),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

// ===== hw/rtl/wbps_match.sv =====
// parallel wildcard compare of the byte window against the pattern
// depends on wbps_pkg
module wbps_match (
	input  wbps_pkg::window_t               window,
	input  wbps_pkg::pattern_t              pattern,
	input  logic [wbps_pkg::LenBits-1:0]    active_len,
	output logic                            hit
);

	logic [wbps_pkg::MaxPattern-1:0] hit_by_len;
	logic [$clog2(wbps_pkg::MaxPattern)-1:0] len_sel;

	// hit_by_len[l] covers a pattern of l+1 bytes; byte i meets window entry l-i
	always_comb begin
		logic ok;
		for (int l = 0; l < wbps_pkg::MaxPattern; l++) begin
			ok = 1'b1;
			for (int i = 0; i <= l; i++) begin
				if (pattern[i] != wbps_pkg::WildcardByte && pattern[i] != window[l-i]) begin
					ok = 1'b0;
				end
			end
			hit_by_len[l] = ok;
		end
	end

	assign len_sel = active_len[$clog2(wbps_pkg::MaxPattern)-1:0] - 1'b1;
	assign hit     = hit_by_len[len_sel];

endmodule

// ===== hw/rtl/wbps_skid.sv =====
// two-entry result buffer: output register plus skid register
// depends on wbps_pkg
module wbps_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wbps_pkg::wbps_out_t push_data,
	output logic               space,
	output logic               result_valid,
	input  logic               result_ready,
	output wbps_pkg::wbps_out_t result_item
);

	logic                main_valid_q;
	logic                skid_valid_q;
	wbps_pkg::wbps_out_t main_q;
	wbps_pkg::wbps_out_t skid_q;
	logic                pop;

	assign pop          = main_valid_q && result_ready;
	assign space        = !skid_valid_q;
	assign result_valid = main_valid_q;
	assign result_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q || pop) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_valid_q || pop) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

// ===== hw/rtl/wbps_checker.sv =====
// port-level checks for the wildcard byte pattern search, bound to the top
// depends on wbps_pkg and assert_macros.svh
`include "assert_macros.svh"

module wbps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                byte_valid,
	input logic                                byte_ready,
	input wbps_pkg::wbps_in_t                  byte_item,
	input logic                                result_valid,
	input logic                                result_ready,
	input wbps_pkg::wbps_out_t                 result_item,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [wbps_pkg::CfgIdxBits-1:0]     cfg_index,
	input logic [wbps_pkg::CfgDataBits-1:0]    cfg_data
);

	// stalled result beat holds
	`ASSERT_IMPL(a_result_hold, result_valid && !result_ready, ##1 (result_valid && $stable(result_item)), "result beat changed while stalled")

	// a not-found result reports offset zero
	`ASSERT_IMPL(a_miss_zero, result_valid && !result_item.match_found, result_item.match_offset == '0, "not-found result with nonzero offset")

	// a new result only follows an accepted byte beat
	`ASSERT_IMPL(a_result_cause, $rose(result_valid), $past(byte_valid && byte_ready), "result without a byte beat")

	// byte side only stalls while a result is pending
	`ASSERT_IMPL(a_stall_cause, !byte_ready, result_valid, "byte side stalled with no result pending")

endmodule

bind wildcard_byte_pattern_search wbps_checker u_checker (.*);
